// ----- sv/srbf_pkg.sv -----
package srbf_pkg;

  // store geometry
  localparam int STORE_DEPTH = 64;
  localparam int SAMPLE_BITS = 10;
  localparam int IDX_BITS    = $clog2(STORE_DEPTH);

  // frame layout
  localparam int          LOW_BITS  = 6;
  localparam logic [7:0]  HIGH_MARK = 8'h80;
  localparam logic [6:0]  LOW_MARK  = 7'h40;

  // configuration register reset values
  localparam logic [7:0]  START_CODE_RST = 8'h5A;
  localparam logic [7:0]  STOP_CODE_RST  = 8'h55;

  // item kinds
  localparam logic [1:0]  CMD_SAMPLE = 2'd0;
  localparam logic [1:0]  CMD_HOST   = 2'd1;
  localparam logic [1:0]  CMD_DRAIN  = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_BITS   = 2;
  localparam logic [1:0]  REG_START_CODE = 2'd0;
  localparam logic [1:0]  REG_STOP_CODE  = 2'd1;

  // controller to datapath
  typedef struct packed {
    logic wr_sample;
    logic do_host;
    logic rd_issue;
    logic load_out;
  } srbf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic capture;
    logic empty;
    logic rd_last;
    logic out_free;
  } srbf_stat_t;

  // wrapping index increment
  function automatic logic [IDX_BITS-1:0] next_idx(input logic [IDX_BITS-1:0] idx);
    logic [IDX_BITS-1:0] res;
    if (idx == IDX_BITS'(STORE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

endpackage

// ----- sv/sample_ring_buffer_framer_top.sv -----
// Circular sample store of 64 ten-bit entries with two-byte framing on drain.
// Samples and host bytes are taken one per cycle when no drain is running;
// a start code clears both indices and enables capture, a stop code disables
// it. A drain request holds the input side while each stored sample gets a
// registered store read, then a load of the output register that waits
// while the output is stalled; a drain with nothing stored does not hold it.
// The output register lets the final frame wait while the next item is taken.
// Configuration writes are always ready and take effect on the next cycle.
module sample_ring_buffer_framer_top
  import srbf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              command_i,
  input  logic [SAMPLE_BITS-1:0]  sample_value_i,
  input  logic [7:0]              host_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              high_frame_byte_o,
  output logic [6:0]              low_frame_byte_o,
  output logic                    last_of_run_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [7:0]              cfg_data_i
);

  srbf_cmd_t  cmd;
  srbf_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // sequencer
  srbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // store, indices and framing
  srbf_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .sample_value_i    (sample_value_i),
    .host_byte_i       (host_byte_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .high_frame_byte_o (high_frame_byte_o),
    .low_frame_byte_o  (low_frame_byte_o),
    .last_of_run_o     (last_of_run_o)
  );

endmodule

// ----- sv/srbf_ctrl.sv -----
module srbf_ctrl
  import srbf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  srbf_stat_t stat_i,
  output srbf_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // input taken only between drain runs
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_SAMPLE: cmd_o.wr_sample = stat_i.capture;
            CMD_HOST:   cmd_o.do_host   = 1'b1;
            CMD_DRAIN: begin
              if (stat_i.capture && !stat_i.empty) begin
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = stat_i.rd_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/srbf_datapath.sv -----
module srbf_datapath
  import srbf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  srbf_cmd_t               cmd_i,
  output srbf_stat_t              stat_o,
  input  logic [SAMPLE_BITS-1:0]  sample_value_i,
  input  logic [7:0]              host_byte_i,
  input  logic                    cfg_valid_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [7:0]              cfg_data_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [7:0]              high_frame_byte_o,
  output logic [6:0]              low_frame_byte_o,
  output logic                    last_of_run_o
);

  logic [SAMPLE_BITS-1:0] store_q [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_q;
  logic [IDX_BITS-1:0]    write_q, read_q, read_nxt;
  logic                   cap_q, rd_last_q;
  logic [7:0]             start_code_q, stop_code_q;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             high_q;
  logic [6:0]             low_q;
  logic                   last_q;

  assign read_nxt = next_idx(read_q);

  // status to controller
  assign stat_o.capture  = cap_q;
  assign stat_o.empty    = (read_q == write_q);
  assign stat_o.rd_last  = rd_last_q;
  assign stat_o.out_free = ~out_valid_q | ~out_stall_i;

  // sample store and registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_sample) begin
      store_q[write_q] <= sample_value_i;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= store_q[read_q];
    end
  end

  // indices, capture flag and end-of-run marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_q   <= '0;
      read_q    <= '0;
      cap_q     <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      if (cmd_i.wr_sample) begin
        write_q <= next_idx(write_q);
      end
      if (cmd_i.do_host) begin
        if (host_byte_i == start_code_q) begin
          write_q <= '0;
          read_q  <= '0;
          cap_q   <= 1'b1;
        end else if (host_byte_i == stop_code_q) begin
          cap_q <= 1'b0;
        end
      end
      if (cmd_i.rd_issue) begin
        read_q    <= read_nxt;
        rd_last_q <= (read_nxt == write_q);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= START_CODE_RST;
      stop_code_q  <= STOP_CODE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START_CODE: start_code_q <= cfg_data_i;
        REG_STOP_CODE:  stop_code_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output register valid
  always_comb begin
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // frame bytes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      high_q <= HIGH_MARK | 8'(rdata_q >> LOW_BITS);
      low_q  <= LOW_MARK | {1'b0, rdata_q[LOW_BITS-1:0]};
      last_q <= rd_last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign high_frame_byte_o = high_q;
  assign low_frame_byte_o  = low_q;
  assign last_of_run_o     = last_q;

endmodule

// ----- dv/sample_ring_buffer_framer_top_tb.sv -----
`timescale 1ns / 1ps

module sample_ring_buffer_framer_top_tb;
  import srbf_pkg::*;

  // codes the block leaves unused
  localparam logic [1:0]              CMD_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 34;
  localparam int CYCLE_LIMIT   = 4000000;

  // one frame pair as seen on the output
  typedef struct packed {
    logic [7:0] hi;
    logic [6:0] lo;
    logic       last;
  } frame_t;

  // one stimulus row; typed rows carry their own expectation
  typedef struct packed {
    logic [1:0]             cmd;
    logic [SAMPLE_BITS-1:0] smp;
    logic [7:0]             hb;
    logic                   typed;
    logic                   has_frame;
    logic [7:0]             hi;
    logic [6:0]             lo;
  } stim_row_t;

  localparam int DIRECTED_COUNT = 25;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{CMD_DRAIN,  10'h000, 8'h00,          1'b1, 1'b0, 8'h00, 7'h00}, // drain straight after reset
    '{CMD_SAMPLE, 10'h155, 8'hFF,          1'b1, 1'b0, 8'h00, 7'h00}, // sample with capture off
    '{CMD_HOST,   10'h3FF, 8'h33,          1'b1, 1'b0, 8'h00, 7'h00}, // byte matching neither code
    '{CMD_UNUSED, 10'h2AA, 8'hA5,          1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_HOST,   10'h000, START_CODE_RST, 1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_DRAIN,  10'h3FF, 8'hFF,          1'b1, 1'b0, 8'h00, 7'h00}, // equal indices
    '{CMD_SAMPLE, 10'h000, 8'h00,          1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_DRAIN,  10'h000, 8'h00,          1'b1, 1'b1, 8'h80, 7'h40},
    '{CMD_SAMPLE, 10'h3FF, 8'hFF,          1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_DRAIN,  10'h000, 8'h00,          1'b1, 1'b1, 8'h8F, 7'h7F},
    '{CMD_SAMPLE, 10'h03F, 8'h5A,          1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_DRAIN,  10'h000, 8'h00,          1'b1, 1'b1, 8'h80, 7'h7F},
    '{CMD_SAMPLE, 10'h3C0, 8'h55,          1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_DRAIN,  10'h000, 8'h00,          1'b1, 1'b1, 8'h8F, 7'h40},
    '{CMD_SAMPLE, 10'h2AA, 8'h00,          1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_SAMPLE, 10'h155, 8'h00,          1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_SAMPLE, 10'h001, 8'h00,          1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_DRAIN,  10'h000, 8'h00,          1'b0, 1'b0, 8'h00, 7'h00},
    '{CMD_HOST,   10'h000, STOP_CODE_RST,  1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_SAMPLE, 10'h100, 8'h00,          1'b1, 1'b0, 8'h00, 7'h00}, // dropped, capture off
    '{CMD_DRAIN,  10'h000, 8'h00,          1'b1, 1'b0, 8'h00, 7'h00}, // drain with capture off
    '{CMD_HOST,   10'h000, START_CODE_RST, 1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_SAMPLE, 10'h200, 8'h00,          1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_SAMPLE, 10'h0C0, 8'h00,          1'b1, 1'b0, 8'h00, 7'h00},
    '{CMD_DRAIN,  10'h000, 8'h00,          1'b0, 1'b0, 8'h00, 7'h00}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              command_i;
  logic [SAMPLE_BITS-1:0]  sample_value_i;
  logic [7:0]              host_byte_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [7:0]              high_frame_byte_o;
  logic [6:0]              low_frame_byte_o;
  logic                    last_of_run_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [7:0]              cfg_data_i;

  sample_ring_buffer_framer_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .sample_value_i    (sample_value_i),
    .host_byte_i       (host_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .high_frame_byte_o (high_frame_byte_o),
    .low_frame_byte_o  (low_frame_byte_o),
    .last_of_run_o     (last_of_run_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // ring buffer shadow state
  logic [SAMPLE_BITS-1:0] ring_store [STORE_DEPTH];
  logic [IDX_BITS-1:0]    ring_wr;
  logic [IDX_BITS-1:0]    ring_rd;
  logic                   ring_capture;
  logic [7:0]             ring_start_code;
  logic [7:0]             ring_stop_code;

  frame_t pending_frames [$];
  frame_t monitor_want;
  int     fail_count;
  int     cycle_count;
  int     acted_items;
  bit     in_quiet;
  int     out_run_left;
  int     out_pick;

  // clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** sample_ring_buffer_framer_top: FAILED **");
      $finish;
    end
  end

  function automatic logic [IDX_BITS-1:0] ring_step(input logic [IDX_BITS-1:0] idx);
    return IDX_BITS'((int'(idx) + 1) % STORE_DEPTH);
  endfunction

  // apply one accepted beat to the shadow state, queueing frames when asked
  task automatic advance_ring_model(input logic [1:0] cmd, input logic [SAMPLE_BITS-1:0] smp,
                                    input logic [7:0] hb, input bit keep, output bit acted);
    logic [SAMPLE_BITS-1:0] s;
    logic [IDX_BITS-1:0]    stop_at;
    frame_t                 f;
    acted = 1'b0;
    case (cmd)
      CMD_SAMPLE: begin
        if (ring_capture) begin
          ring_store[ring_wr] = smp;
          ring_wr = ring_step(ring_wr);
          acted = 1'b1;
        end
      end
      CMD_HOST: begin
        // start wins when both codes match
        if (hb == ring_start_code) begin
          ring_wr = '0;
          ring_rd = '0;
          ring_capture = 1'b1;
          acted = 1'b1;
        end else if (hb == ring_stop_code) begin
          ring_capture = 1'b0;
          acted = 1'b1;
        end
      end
      CMD_DRAIN: begin
        if (ring_capture) begin
          acted = 1'b1;
          stop_at = ring_wr;
          while (ring_rd != stop_at) begin
            s = ring_store[ring_rd];
            f.hi = HIGH_MARK | 8'(s >> LOW_BITS);
            f.lo = LOW_MARK | 7'(s[LOW_BITS-1:0]);
            f.last = (ring_step(ring_rd) == stop_at);
            if (keep) pending_frames.push_back(f);
            ring_rd = ring_step(ring_rd);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (in_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one beat, hold it until taken, then predict
  task automatic send_row(input stim_row_t row);
    int gap;
    bit acted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= row.cmd;
    sample_value_i <= row.smp;
    host_byte_i    <= row.hb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_ring_model(row.cmd, row.smp, row.hb, !row.typed, acted);
    if (row.typed && row.has_frame) pending_frames.push_back({row.hi, row.lo, 1'b1});
    if (acted) acted_items++;
  endtask

  task automatic send_random(input logic [1:0] cmd, input logic [7:0] hb);
    stim_row_t row;
    row = '0;
    row.cmd = cmd;
    // extremes now and then, otherwise any value
    case ($urandom_range(0, 9))
      0:       row.smp = '0;
      1:       row.smp = '1;
      default: row.smp = SAMPLE_BITS'($urandom);
    endcase
    row.hb = hb;
    send_row(row);
  endtask

  // let the block finish all work before touching registers or ending
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input logic [7:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_START_CODE) begin
      ring_start_code = data;
    end else if (idx == REG_STOP_CODE) begin
      ring_stop_code = data;
    end
    cfg_valid_i <= 1'b0;
  endtask

  // output back-pressure: mostly short stalls, some long, some free stretches
  always @(posedge clk_i) begin
    if (out_run_left != 0) begin
      out_run_left <= out_run_left - 1;
    end else begin
      out_pick = $urandom_range(0, 99);
      if (out_pick < 50) begin
        out_stall_i  <= 1'b0;
        out_run_left <= $urandom_range(1, 20);
      end else if (out_pick < 90) begin
        out_stall_i  <= 1'b1;
        out_run_left <= $urandom_range(0, 2);
      end else if (out_pick < 97) begin
        out_stall_i  <= 1'b0;
        out_run_left <= $urandom_range(40, 120);
      end else begin
        out_stall_i  <= 1'b1;
        out_run_left <= $urandom_range(8, 30);
      end
    end
  end

  // frame checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_frames.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected frame: high %h low %h last %b",
                   high_frame_byte_o, low_frame_byte_o, last_of_run_o);
        end
        fail_count++;
      end else begin
        monitor_want = pending_frames.pop_front();
        if (high_frame_byte_o !== monitor_want.hi || low_frame_byte_o !== monitor_want.lo ||
            last_of_run_o !== monitor_want.last) begin
          if (fail_count < 10) begin
            $display("frame mismatch: expected high %h low %h last %b, got %h %h %b",
                     monitor_want.hi, monitor_want.lo, monitor_want.last,
                     high_frame_byte_o, low_frame_byte_o, last_of_run_o);
          end
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int          phase;
    int          pick;
    int          burst;
    int          goal;
    logic [7:0]  start_code;
    logic [7:0]  stop_code;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CMD_SAMPLE;
    sample_value_i = '0;
    host_byte_i    = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_START_CODE;
    cfg_data_i     = '0;
    fail_count     = 0;
    cycle_count    = 0;
    acted_items    = 0;
    in_quiet       = 1'b0;
    out_run_left   = 0;
    ring_wr         = '0;
    ring_rd         = '0;
    ring_capture    = 1'b0;
    ring_start_code = START_CODE_RST;
    ring_stop_code  = STOP_CODE_RST;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at reset codes
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_row(DIRECTED_ROWS[i]);
    end

    // random phases, one code setting each
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          start_code = 8'h00;
          stop_code  = 8'hFF;
        end
        1: begin
          start_code = 8'hFF;
          stop_code  = 8'h00;
        end
        2: begin
          // equal codes: start action takes precedence
          start_code = 8'($urandom);
          stop_code  = start_code;
        end
        3: begin
          start_code = 8'($urandom);
          stop_code  = 8'($urandom);
        end
        default: begin
          start_code = START_CODE_RST;
          stop_code  = STOP_CODE_RST;
        end
      endcase
      write_register(REG_START_CODE, start_code);
      write_register(REG_STOP_CODE, stop_code);
      if (phase == 2) write_register(REG_SPARE_LO, 8'($urandom));
      if (phase == 3) write_register(REG_SPARE_HI, 8'($urandom));

      goal = acted_items + PHASE_ITEMS;
      send_random(CMD_HOST, ring_start_code);
      while (acted_items < goal) begin
        in_quiet = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // run of samples then a drain; now and then long enough to wrap
          burst = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 6);
          repeat (burst) send_random(CMD_SAMPLE, 8'($urandom));
          send_random(CMD_DRAIN, 8'($urandom));
        end else if (pick < 80) begin
          send_random(CMD_DRAIN, 8'($urandom));
        end else if (pick < 86) begin
          // capture off for a while, then back on
          send_random(CMD_HOST, ring_stop_code);
          repeat ($urandom_range(0, 3)) send_random(CMD_SAMPLE, 8'($urandom));
          send_random(CMD_DRAIN, 8'($urandom));
          send_random(CMD_HOST, ring_start_code);
        end else if (pick < 92) begin
          send_random(CMD_HOST, 8'($urandom));
        end else if (pick < 96) begin
          send_random(CMD_UNUSED, 8'($urandom));
        end else begin
          send_random(CMD_HOST, ring_start_code);
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("** sample_ring_buffer_framer_top: PASSED **");
    end else begin
      $display("** sample_ring_buffer_framer_top: FAILED **");
    end
    $finish;
  end

endmodule
